>>> design/modbus_rtu_master_transaction_core_assert.svh
// ----------------------------------------------------------------------------
// Modbus RTU master core assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MASTER_TRANSACTION_CORE_ASSERT_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_CORE_ASSERT_SVH

// clocked assertion with reset disable
`define MRTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assertion that applies only while a result is shown
`define MRTU_ASSERT_OUT(label, cond, prop, msg) \
  `MRTU_ASSERT(label, (!empty && (cond)) |-> (prop), msg)

`endif

>>> design/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU master package
// Shared types, codes and the CRC-16 step.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam int MaxWordsDef   = 16;
  localparam int FrameBytesDef = 256;

  typedef enum logic [2:0] {
    OP_APPEND_WORD = 3'd0,
    OP_APPEND_BIT  = 3'd1,
    OP_START       = 3'd2,
    OP_RX_BYTE     = 3'd3,
    OP_TIMEOUT     = 3'd4
  } op_e;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SLAVE = 3'd1;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT   = 3'd3;
  localparam logic [2:0] ST_BAD_CRC   = 3'd4;
  localparam logic [2:0] ST_EXCEPTION = 3'd5;

  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    op_e         op;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] rd_addr;
    logic [15:0] rd_qty;
    logic [15:0] wr_addr;
    logic [15:0] wr_qty;
    logic [15:0] data;
    logic [7:0]  rx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [15:0] word;
    logic [3:0]  idx;
    logic [2:0]  status;
    logic [7:0]  exc;
    logic [4:0]  wcnt;
    logic        last;
  } res_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/mrtu_front.sv
// ----------------------------------------------------------------------------
// Modbus RTU master front end
// Accepts items, drops undefined operations, queues commands for the engine.
// ----------------------------------------------------------------------------
module mrtu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          slave_id_i,
  input  logic [7:0]          function_code_i,
  input  logic [15:0]         read_address_i,
  input  logic [15:0]         read_quantity_i,
  input  logic [15:0]         write_address_i,
  input  logic [15:0]         write_quantity_i,
  input  logic [15:0]         data_word_i,
  input  logic [7:0]          rx_byte_i,
  output logic                cmd_valid_o,
  output mrtu_pkg::cmd_t      cmd_o,
  input  logic                cmd_ready_i
);

  mrtu_pkg::cmd_t buf_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           keep;
  logic           wr, rd;
  mrtu_pkg::cmd_t cmd_n;

  always_comb begin
    unique case (operation_i)
      mrtu_pkg::OP_APPEND_WORD, mrtu_pkg::OP_APPEND_BIT, mrtu_pkg::OP_START,
      mrtu_pkg::OP_RX_BYTE, mrtu_pkg::OP_TIMEOUT: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd_n.op      = mrtu_pkg::op_e'(operation_i);
    cmd_n.slave   = slave_id_i;
    cmd_n.func    = function_code_i;
    cmd_n.rd_addr = read_address_i;
    cmd_n.rd_qty  = read_quantity_i;
    cmd_n.wr_addr = write_address_i;
    cmd_n.wr_qty  = write_quantity_i;
    cmd_n.data    = data_word_i;
    cmd_n.rx      = rx_byte_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign wr          = push && !full && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd          = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= cmd_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> design/mrtu_back.sv
// ----------------------------------------------------------------------------
// Modbus RTU master engine
// Transmit buffer, request framing, receive parsing, CRC check and unpacking.
// ----------------------------------------------------------------------------
module mrtu_back #(
  parameter int MaxWords   = mrtu_pkg::MaxWordsDef,
  parameter int FrameBytes = mrtu_pkg::FrameBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_data_i,
  input  logic           cmd_valid_i,
  input  mrtu_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  output logic           res_valid_o,
  output mrtu_pkg::res_t res_o,
  input  logic           res_ready_i
);

  localparam int TIW = $clog2(MaxWords);
  localparam int WCW = $clog2(MaxWords + 1);
  localparam int BCW = WCW + 4;
  localparam int FAW = $clog2(FrameBytes);
  localparam int HdrMax = 11;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TXH  = 4'd1;
  localparam logic [3:0] S_TXRD = 4'd2;
  localparam logic [3:0] S_TXD  = 4'd3;
  localparam logic [3:0] S_TXCL = 4'd4;
  localparam logic [3:0] S_TXCH = 4'd5;
  localparam logic [3:0] S_HDR  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_UNRA = 4'd8;
  localparam logic [3:0] S_UNRB = 4'd9;
  localparam logic [3:0] S_UNEM = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_HEAD = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [3:0]  state_q, state_d;
  logic [3:0]  hunt_q;

  logic [15:0] tx_mem [MaxWords];
  logic [15:0] tx_rd_q;
  logic        tx_we;
  logic [TIW-1:0] tx_waddr, tx_raddr;
  logic [15:0] tx_wdata;
  logic [WCW-1:0] wcnt_q, wcnt_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [15:0] cur_q, cur_d;

  logic [7:0]  pslave_q, pslave_d, pfn_q, pfn_d;
  logic [7:0]  hdr_q [HdrMax];
  logic [7:0]  hdr_n [HdrMax];
  logic        hdr_we;
  logic [3:0]  hlen_q, hlen_d, hi_q, hi_d;
  logic [5:0]  dlen_q, dlen_d, di_q, di_d;
  logic        dcoil_q, dcoil_d;
  logic [15:0] crctx_q, crctx_d;

  logic [7:0]  rx_mem [FrameBytes];
  logic [7:0]  rx_rd_q;
  logic        rx_we;
  logic [FAW-1:0] rx_waddr, rx_raddr;
  logic [1:0]  ph_q, ph_d;
  logic [8:0]  fc_q, fc_d, exp_q, exp_d;
  logic [3:0]  tries_q, tries_d;
  logic [15:0] crcrx_q, crcrx_d;
  logic [7:0]  b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;

  logic [3:0]  ui_q, ui_d;
  logic [4:0]  words_q, words_d;
  logic        coils_q, coils_d;
  logic [7:0]  a_q, a_d;
  logic [2:0]  fst_q, fst_d;
  logic [7:0]  fexc_q, fexc_d;
  logic [4:0]  fwc_q, fwc_d;

  // scratch
  logic [15:0] wbit;
  logic [3:0]  bi;
  logic [3:0]  tdec;
  logic        take;
  logic [8:0]  tb_fc;
  logic [7:0]  extra;
  logic [8:0]  exp_n;
  logic [7:0]  wraw;
  logic [13:0] ccnt;
  logic [5:0]  coil_cnt;
  logic [4:0]  reg_cnt;
  logic [7:0]  txb;
  logic [15:0] uw;

  always_comb begin
    state_d = state_q;
    wcnt_d = wcnt_q; bcnt_d = bcnt_q; cur_d = cur_q;
    pslave_d = pslave_q; pfn_d = pfn_q;
    hlen_d = hlen_q; hi_d = hi_q; dlen_d = dlen_q; di_d = di_q; dcoil_d = dcoil_q;
    crctx_d = crctx_q;
    ph_d = ph_q; fc_d = fc_q; exp_d = exp_q; tries_d = tries_q; crcrx_d = crcrx_q;
    b0_d = b0_q; b1_d = b1_q; b2_d = b2_q;
    ui_d = ui_q; words_d = words_q; coils_d = coils_q; a_d = a_q;
    fst_d = fst_q; fexc_d = fexc_q; fwc_d = fwc_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o = '0;
    tx_we = 1'b0; tx_waddr = '0; tx_wdata = cmd_i.data; tx_raddr = '0;
    rx_we = 1'b0; rx_waddr = fc_q[FAW-1:0]; rx_raddr = '0;
    hdr_we = 1'b0;
    for (int k = 0; k < HdrMax; k++) hdr_n[k] = 8'h00;
    wbit = 16'h0000; bi = bcnt_q[3:0];
    tdec = 4'd0; take = 1'b0; tb_fc = fc_q + 9'd1;
    extra = 8'd0; exp_n = 9'd5; wraw = 8'd0;
    ccnt = 14'(({1'b0, cmd_i.wr_qty} + 17'd7) >> 3);
    coil_cnt = (ccnt > 14'(2 * MaxWords)) ? 6'(2 * MaxWords) : ccnt[5:0];
    reg_cnt = (cmd_i.wr_qty > 16'(MaxWords)) ? 5'(MaxWords) : cmd_i.wr_qty[4:0];
    txb = 8'h00; uw = 16'h0000;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.op)
            mrtu_pkg::OP_APPEND_WORD: begin
              if (wcnt_q < WCW'(MaxWords)) begin
                tx_we    = 1'b1;
                tx_waddr = wcnt_q[TIW-1:0];
                wcnt_d   = wcnt_q + 1'b1;
                bcnt_d   = {wcnt_d, 4'h0};
              end
            end
            mrtu_pkg::OP_APPEND_BIT: begin
              if (bcnt_q[BCW-1:4] < WCW'(MaxWords)) begin
                wbit     = (bi != 4'd0) ? cur_q : 16'h0000;
                wbit[bi] = cmd_i.data[0];
                cur_d    = wbit;
                tx_we    = 1'b1;
                tx_waddr = bcnt_q[TIW+3:4];
                tx_wdata = wbit;
                bcnt_d   = bcnt_q + 1'b1;
                wcnt_d   = bcnt_d[BCW-1:4];
              end
            end
            mrtu_pkg::OP_START: begin
              hdr_we = 1'b1;
              hdr_n[0] = cmd_i.slave;
              hdr_n[1] = cmd_i.func;
              hlen_d = 4'd2; dlen_d = 6'd0; dcoil_d = 1'b0;
              case (cmd_i.func)
                8'd1, 8'd2, 8'd3, 8'd4, 8'd23: begin
                  hdr_n[2] = cmd_i.rd_addr[15:8]; hdr_n[3] = cmd_i.rd_addr[7:0];
                  hdr_n[4] = cmd_i.rd_qty[15:8];  hdr_n[5] = cmd_i.rd_qty[7:0];
                  hlen_d = 4'd6;
                  if (cmd_i.func == 8'd23) begin
                    hdr_n[6] = cmd_i.wr_addr[15:8]; hdr_n[7] = cmd_i.wr_addr[7:0];
                    hdr_n[8] = cmd_i.wr_qty[15:8];  hdr_n[9] = cmd_i.wr_qty[7:0];
                    hdr_n[10] = {2'b00, reg_cnt, 1'b0};
                    hlen_d = 4'd11;
                    dlen_d = {reg_cnt, 1'b0};
                  end
                end
                8'd5, 8'd15, 8'd16: begin
                  hdr_n[2] = cmd_i.wr_addr[15:8]; hdr_n[3] = cmd_i.wr_addr[7:0];
                  hdr_n[4] = cmd_i.wr_qty[15:8];  hdr_n[5] = cmd_i.wr_qty[7:0];
                  hlen_d = 4'd6;
                  if (cmd_i.func == 8'd15) begin
                    hdr_n[6] = {2'b00, coil_cnt};
                    hlen_d = 4'd7; dlen_d = coil_cnt; dcoil_d = 1'b1;
                  end else if (cmd_i.func == 8'd16) begin
                    hdr_n[6] = {2'b00, reg_cnt, 1'b0};
                    hlen_d = 4'd7; dlen_d = {reg_cnt, 1'b0};
                  end
                end
                8'd6, 8'd22: begin
                  hdr_n[2] = cmd_i.wr_addr[15:8]; hdr_n[3] = cmd_i.wr_addr[7:0];
                  hlen_d = 4'd4;
                  dlen_d = (cmd_i.func == 8'd6) ? 6'd2 : 6'd4;
                end
                default: ;
              endcase
              pslave_d = cmd_i.slave;
              pfn_d    = cmd_i.func;
              hi_d = 4'd0; di_d = 6'd0;
              crctx_d = mrtu_pkg::CrcSeed;
              wcnt_d = '0; bcnt_d = '0;
              fc_d = 9'd0; exp_d = 9'd0; crcrx_d = mrtu_pkg::CrcSeed;
              tries_d = (hunt_q != 4'd0) ? hunt_q : 4'd1;
              ph_d = PH_HUNT;
              state_d = S_TXH;
            end
            mrtu_pkg::OP_RX_BYTE: begin
              case (ph_q)
                PH_HUNT: begin
                  tdec = (tries_q != 4'd0) ? tries_q - 4'd1 : 4'd0;
                  tries_d = tdec;
                  if (cmd_i.rx == pslave_q || tdec == 4'd0) begin
                    take = 1'b1;
                    ph_d = PH_HEAD;
                  end
                end
                PH_HEAD: begin
                  take = 1'b1;
                  if (tb_fc >= 9'd5) state_d = S_HDR;
                end
                PH_BODY: begin
                  take = 1'b1;
                  if (tb_fc >= exp_q) state_d = S_CHK;
                end
                default: ;
              endcase
              if (take) begin
                rx_we   = (fc_q < 9'(FrameBytes));
                if (fc_q == 9'd0) b0_d = cmd_i.rx;
                if (fc_q == 9'd1) b1_d = cmd_i.rx;
                if (fc_q == 9'd2) b2_d = cmd_i.rx;
                crcrx_d = mrtu_pkg::crc_feed(crcrx_q, cmd_i.rx);
                fc_d    = tb_fc;
              end
            end
            mrtu_pkg::OP_TIMEOUT: begin
              if (ph_q != PH_IDLE) begin
                fst_d = mrtu_pkg::ST_TIMEOUT; fexc_d = 8'h00; fwc_d = 5'd0;
                ph_d = PH_IDLE;
                state_d = S_FIN;
              end
            end
            default: ;
          endcase
        end
      end

      S_TXH: begin
        txb = hdr_q[hi_q];
        res_valid_o = 1'b1;
        res_o.kind = mrtu_pkg::KIND_TX;
        res_o.tx = txb;
        if (res_ready_i) begin
          crctx_d = mrtu_pkg::crc_feed(crctx_q, txb);
          hi_d = hi_q + 4'd1;
          if (hi_d == hlen_q) state_d = (dlen_q != 6'd0) ? S_TXRD : S_TXCL;
        end
      end

      S_TXRD: begin
        tx_raddr = di_q[TIW:1];
        state_d = S_TXD;
      end

      S_TXD: begin
        tx_raddr = di_q[TIW:1];
        txb = (di_q[0] ^ dcoil_q) ? tx_rd_q[7:0] : tx_rd_q[15:8];
        res_valid_o = 1'b1;
        res_o.kind = mrtu_pkg::KIND_TX;
        res_o.tx = txb;
        if (res_ready_i) begin
          crctx_d = mrtu_pkg::crc_feed(crctx_q, txb);
          di_d = di_q + 6'd1;
          state_d = (di_d == dlen_q) ? S_TXCL : S_TXRD;
        end
      end

      S_TXCL: begin
        res_valid_o = 1'b1;
        res_o.kind = mrtu_pkg::KIND_TX;
        res_o.tx = crctx_q[7:0];
        if (res_ready_i) state_d = S_TXCH;
      end

      S_TXCH: begin
        res_valid_o = 1'b1;
        res_o.kind = mrtu_pkg::KIND_TX;
        res_o.tx = crctx_q[15:8];
        res_o.last = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end

      S_HDR: begin
        fexc_d = 8'h00; fwc_d = 5'd0;
        if (b1_q[7]) begin
          fst_d = mrtu_pkg::ST_EXCEPTION; fexc_d = b2_q;
          ph_d = PH_IDLE; state_d = S_FIN;
        end else if (b1_q != pfn_q) begin
          fst_d = mrtu_pkg::ST_BAD_FUNC;
          ph_d = PH_IDLE; state_d = S_FIN;
        end else if (b0_q != pslave_q) begin
          fst_d = mrtu_pkg::ST_BAD_SLAVE;
          ph_d = PH_IDLE; state_d = S_FIN;
        end else begin
          case (b1_q)
            8'd1, 8'd2, 8'd3, 8'd4, 8'd23: extra = b2_q;
            8'd5, 8'd6, 8'd15, 8'd16:      extra = 8'd3;
            8'd22:                          extra = 8'd5;
            default:                        extra = 8'd0;
          endcase
          exp_n = 9'd5 + {1'b0, extra};
          exp_d = exp_n;
          if (fc_q >= exp_n) begin
            state_d = S_CHK;
          end else begin
            ph_d = PH_BODY;
            state_d = S_IDLE;
          end
        end
      end

      S_CHK: begin
        ph_d = PH_IDLE;
        fexc_d = 8'h00;
        coils_d = (b1_q == 8'd1 || b1_q == 8'd2);
        if (crcrx_q != 16'h0000) begin
          fst_d = mrtu_pkg::ST_BAD_CRC; fwc_d = 5'd0;
          state_d = S_FIN;
        end else begin
          if (coils_d) wraw = {1'b0, b2_q[7:1]} + {7'd0, b2_q[0]};
          else if (b1_q == 8'd3 || b1_q == 8'd4 || b1_q == 8'd23) wraw = {1'b0, b2_q[7:1]};
          words_d = (wraw > 8'(MaxWords)) ? 5'(MaxWords) : wraw[4:0];
          ui_d = 4'd0;
          fst_d = mrtu_pkg::ST_OK; fwc_d = words_d;
          state_d = (words_d == 5'd0) ? S_FIN : S_UNRA;
        end
      end

      S_UNRA: begin
        rx_raddr = FAW'({1'b0, ui_q, 1'b1} + 6'd2);
        state_d = S_UNRB;
      end

      S_UNRB: begin
        rx_raddr = FAW'({1'b0, ui_q, 1'b0} + 6'd4);
        a_d = rx_rd_q;
        state_d = S_UNEM;
      end

      S_UNEM: begin
        rx_raddr = FAW'({1'b0, ui_q, 1'b0} + 6'd4);
        if (coils_q) begin
          uw = ({1'b0, ui_q, 1'b1} < {1'b0, b2_q}) ? {rx_rd_q, a_q} : {8'h00, a_q};
        end else begin
          uw = {a_q, rx_rd_q};
        end
        res_valid_o = 1'b1;
        res_o.kind = mrtu_pkg::KIND_WORD;
        res_o.word = uw;
        res_o.idx = ui_q;
        if (res_ready_i) begin
          ui_d = ui_q + 4'd1;
          state_d = ({1'b0, ui_q} + 5'd1 == words_q) ? S_FIN : S_UNRA;
        end
      end

      S_FIN: begin
        res_valid_o = 1'b1;
        res_o.kind = mrtu_pkg::KIND_STATUS;
        res_o.status = fst_q;
        res_o.exc = fexc_q;
        res_o.wcnt = fwc_q;
        res_o.last = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_waddr] <= tx_wdata;
    tx_rd_q <= tx_mem[tx_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_waddr] <= cmd_i.rx;
    rx_rd_q <= rx_mem[rx_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      for (int k = 0; k < HdrMax; k++) hdr_q[k] <= hdr_n[k];
    end
    cur_q <= cur_d;
    dlen_q <= dlen_d;
    dcoil_q <= dcoil_d;
    b0_q <= b0_d; b1_q <= b1_d; b2_q <= b2_d;
    words_q <= words_d; coils_q <= coils_d; a_q <= a_d;
    fst_q <= fst_d; fexc_q <= fexc_d; fwc_q <= fwc_d;
    hlen_q <= hlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hunt_q   <= 4'd5;
      wcnt_q   <= '0;
      bcnt_q   <= '0;
      pslave_q <= 8'h00;
      pfn_q    <= 8'h00;
      hi_q     <= 4'd0;
      di_q     <= 6'd0;
      crctx_q  <= mrtu_pkg::CrcSeed;
      ph_q     <= PH_IDLE;
      fc_q     <= 9'd0;
      exp_q    <= 9'd0;
      tries_q  <= 4'd0;
      crcrx_q  <= mrtu_pkg::CrcSeed;
      ui_q     <= 4'd0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) hunt_q <= cfg_data_i;
      wcnt_q   <= wcnt_d;
      bcnt_q   <= bcnt_d;
      pslave_q <= pslave_d;
      pfn_q    <= pfn_d;
      hi_q     <= hi_d;
      di_q     <= di_d;
      crctx_q  <= crctx_d;
      ph_q     <= ph_d;
      fc_q     <= fc_d;
      exp_q    <= exp_d;
      tries_q  <= tries_d;
      crcrx_q  <= crcrx_d;
      ui_q     <= ui_d;
    end
  end

endmodule

>>> design/mrtu_outq.sv
// ----------------------------------------------------------------------------
// Modbus RTU master result queue
// Two-entry queue that decouples the engine from the result consumer.
// ----------------------------------------------------------------------------
module mrtu_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  mrtu_pkg::res_t in_i,
  output logic           in_ready_o,
  output logic           empty,
  input  logic           pop,
  output mrtu_pkg::res_t out_o
);

  mrtu_pkg::res_t buf_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign in_ready_o = (cnt_q != 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign wr         = in_valid_i && in_ready_o;
  assign rd         = pop && !empty;
  assign out_o      = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> design/modbus_rtu_master_transaction_core.sv
// ----------------------------------------------------------------------------
// Modbus RTU master transaction core
// Items are queued, then executed one at a time by the engine; results leave
// through a two-entry queue. During a start request each data byte waits for
// a transmit buffer read. A completed response goes through the header and
// CRC checks, and each unpacked word is read through the single frame memory
// read port.
// ----------------------------------------------------------------------------
module modbus_rtu_master_transaction_core #(
  parameter int MaxWords   = mrtu_pkg::MaxWordsDef,
  parameter int FrameBytes = mrtu_pkg::FrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  slave_id_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] read_address_i,
  input  logic [15:0] read_quantity_i,
  input  logic [15:0] write_address_i,
  input  logic [15:0] write_quantity_i,
  input  logic [15:0] data_word_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [15:0] response_word_o,
  output logic [3:0]  word_index_o,
  output logic [2:0]  status_o,
  output logic [7:0]  exception_code_o,
  output logic [4:0]  word_count_o,
  output logic        last_o
);

  logic           cmd_valid, cmd_ready;
  mrtu_pkg::cmd_t cmd;
  logic           res_valid, res_ready;
  mrtu_pkg::res_t res, head;

  mrtu_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .operation_i, .slave_id_i, .function_code_i,
    .read_address_i, .read_quantity_i, .write_address_i, .write_quantity_i,
    .data_word_i, .rx_byte_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  mrtu_back #(.MaxWords(MaxWords), .FrameBytes(FrameBytes)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .res_valid_o(res_valid), .res_o(res), .res_ready_i(res_ready)
  );

  mrtu_outq u_outq (
    .clk_i, .rst_ni,
    .in_valid_i(res_valid), .in_i(res), .in_ready_o(res_ready),
    .empty, .pop, .out_o(head)
  );

  assign kind_o           = head.kind;
  assign tx_byte_o        = head.tx;
  assign response_word_o  = head.word;
  assign word_index_o     = head.idx;
  assign status_o         = head.status;
  assign exception_code_o = head.exc;
  assign word_count_o     = head.wcnt;
  assign last_o           = head.last;

endmodule

>>> design/mrtu_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU master port checker
// Result-side properties observed on the top-level ports.
// ----------------------------------------------------------------------------
`include "modbus_rtu_master_transaction_core_assert.svh"

module mrtu_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind_o,
  input logic [2:0]  status_o,
  input logic [4:0]  word_count_o,
  input logic        last_o
);

  `MRTU_ASSERT_OUT(a_kind_legal, 1'b1, kind_o != 2'd3, "illegal result kind")
  `MRTU_ASSERT_OUT(a_word_not_last, kind_o == mrtu_pkg::KIND_WORD, !last_o, "word marked last")
  `MRTU_ASSERT_OUT(a_status_last, kind_o == mrtu_pkg::KIND_STATUS, last_o, "status not last")
  `MRTU_ASSERT_OUT(a_fail_wcnt, status_o != mrtu_pkg::ST_OK, word_count_o == '0, "count on fail")
  `MRTU_ASSERT(a_hold, (!empty && !pop) |=> !empty, "result dropped without transfer")

endmodule

bind modbus_rtu_master_transaction_core mrtu_port_checker u_mrtu_port_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .empty(empty), .pop(pop), .kind_o(kind_o),
  .status_o(status_o), .word_count_o(word_count_o), .last_o(last_o)
);
